FILE: rtl/cfsm_pkg.sv
`default_nettype none

package cfsm_pkg;

    // pattern store depth and derived widths
    localparam int PAT_MAX = 64;
    localparam int LEN_W   = $clog2(PAT_MAX + 1);
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 16;
    localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // port widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    // opcodes
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // ascii folding
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        logic              is_text;
        logic              first;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    // found sits in the lowest bit
    typedef struct packed {
        logic             overflow;
        logic [POS_W-1:0] count;
        logic [POS_W-1:0] start;
        logic             found;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/case_folded_substring_matcher.sv
// an item taken on s_ passes the front register, a queue entry and the result register
// throughput: one item per cycle without output stalls, whole pattern vs window in parallel
// the front register, a two-item queue and the result register keep both sides decoupled
// reset: synchronous active-low aresetn clears length, counters, window and flags
// the pattern store itself is not cleared, only entries below the length are used
`default_nettype none

module case_folded_substring_matcher (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input items
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [cfsm_pkg::IN_TDATA_W-1:0]      s_tdata,  // char_value[7:0], first_flag[8]
    input  wire logic                                 s_tuser,  // opcode
    // result items
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [cfsm_pkg::OUT_TDATA_W-1:0]          m_tdata   // match_found[0],
                                                                // match_start[16:1],
                                                                // match_count[32:17],
                                                                // pattern_overflow[33]
);
    import cfsm_pkg::*;

    // front to queue
    logic    push_valid, push_ready;
    cmd_t    push_cmd;
    // queue to back
    logic    pop_valid, pop_ready;
    cmd_t    pop_cmd;
    // back result
    result_t res_data;

    // front: takes items, folds case and classifies pattern or text
    cfsm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // short queue so either side can stall on its own
    cfsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // back: pattern store, text window, parallel compare and counters
    cfsm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res_data)
    );

    // pad the result up to whole bytes
    assign m_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_data};

    // the front never offers an item to a full queue without holding it
    a_queue_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && !push_ready |=> push_valid && $stable(push_cmd))
        else $error("front item dropped while queue full");

    // a reported occurrence always has a non-zero running count
    a_match_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[32:17] != '0)
        else $error("match reported with zero count");

    // start position is zero whenever nothing matched
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == '0)
        else $error("non-zero start without a match");

endmodule

`default_nettype wire

FILE: rtl/cfsm_front.sv
`default_nettype none

module cfsm_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [cfsm_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                                 s_tuser,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output cfsm_pkg::cmd_t                            push_cmd
);
    import cfsm_pkg::*;

    logic front_valid_reg, front_valid_next;
    cmd_t front_cmd_reg, front_cmd_next;
    logic take;

    assign s_tready   = !front_valid_reg || push_ready;
    assign take       = s_tvalid && s_tready;
    assign push_valid = front_valid_reg;
    assign push_cmd   = front_cmd_reg;

    always_comb begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (take) begin
            front_valid_next       = 1'b1;
            front_cmd_next.is_text = (s_tuser == OP_TEXT);
            front_cmd_next.first  = s_tdata[CHAR_W];
            front_cmd_next.ch     = fold_upper(s_tdata[CHAR_W-1:0]);
        end else if (push_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_cmd_reg <= front_cmd_next;
    end

endmodule

`default_nettype wire

FILE: rtl/cfsm_queue.sv
`default_nettype none

module cfsm_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire cfsm_pkg::cmd_t  push_cmd,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output cfsm_pkg::cmd_t       pop_cmd
);
    import cfsm_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cfsm_back.sv
`default_nettype none

module cfsm_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire cfsm_pkg::cmd_t    pop_cmd,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output cfsm_pkg::result_t      res_data
);
    import cfsm_pkg::*;

    logic [CHAR_W-1:0] pat_reg [PAT_MAX];
    logic [CHAR_W-1:0] win_reg [PAT_MAX];
    logic [CHAR_W-1:0] win_sh  [PAT_MAX];
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  total_reg, total_next;
    logic              ovf_reg, ovf_next;
    logic              res_valid_reg;
    result_t           res_data_reg, res_data_next;

    logic              pop;
    logic              pat_shift, win_load;
    logic [LEN_W-1:0]  plen_base, fill_base;
    logic [POS_W-1:0]  pos_base, total_base;
    logic [PAT_MAX-1:0] hit;
    logic              found;
    logic [POS_W:0]    start_wide;

    assign pop_ready = !res_valid_reg || res_ready;
    assign pop       = pop_valid && pop_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // window after this character shifts in, cleared on a text restart
    always_comb begin
        win_sh[0] = pop_cmd.ch;
        for (int k = 1; k < PAT_MAX; k++) begin
            win_sh[k] = pop_cmd.first ? '0 : win_reg[k-1];
        end
        for (int k = 0; k < PAT_MAX; k++) begin
            hit[k] = (win_sh[k] == pat_reg[k]) || (LEN_W'(k) >= len_reg);
        end
    end

    always_comb begin
        plen_base  = pop_cmd.first ? '0 : len_reg;
        fill_base  = pop_cmd.first ? '0 : fill_reg;
        pos_base   = pop_cmd.first ? '0 : pos_reg;
        total_base = pop_cmd.first ? '0 : total_reg;

        len_next   = len_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        pat_shift  = 1'b0;
        win_load   = 1'b0;
        found      = 1'b0;
        start_wide = '0;
        res_data_next = res_data_reg;

        if (pop) begin
            if (pop_cmd.is_text) begin
                win_load  = 1'b1;
                fill_next = (fill_base == LEN_W'(PAT_MAX)) ? fill_base : fill_base + 1'b1;
                found     = (len_reg != '0) && (fill_next >= len_reg) && (&hit);
                start_wide = ({1'b0, pos_base} + 1'b1) - (POS_W + 1)'(len_reg);
                total_next = (found && total_base != POS_LIMIT) ? total_base + 1'b1
                                                                 : total_base;
                pos_next   = (pos_base != POS_LIMIT) ? pos_base + 1'b1 : pos_base;
                res_data_next.found    = found;
                res_data_next.start    = found ? start_wide[POS_W-1:0] : '0;
                res_data_next.count    = total_next;
                res_data_next.overflow = ovf_reg;
            end else begin
                ovf_next = pop_cmd.first ? 1'b0 : ovf_reg;
                if (plen_base < LEN_W'(PAT_MAX)) begin
                    pat_shift = 1'b1;
                    len_next  = plen_base + 1'b1;
                end else begin
                    len_next  = plen_base;
                    ovf_next  = 1'b1;
                end
                res_data_next.found    = 1'b0;
                res_data_next.start    = '0;
                res_data_next.count    = total_reg;
                res_data_next.overflow = ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < PAT_MAX; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            if (pop) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (win_load) begin
                for (int k = 0; k < PAT_MAX; k++) begin
                    win_reg[k] <= win_sh[k];
                end
            end
        end
    end

    // pattern kept newest first so entry k lines up with window entry k
    always_ff @(posedge aclk) begin
        res_data_reg <= res_data_next;
        if (pat_shift) begin
            pat_reg[0] <= pop_cmd.ch;
            for (int k = 1; k < PAT_MAX; k++) begin
                pat_reg[k] <= pat_reg[k-1];
            end
        end
    end

endmodule

`default_nettype wire

FILE: dv/case_folded_substring_matcher_test.sv
`timescale 1ns / 1ps

module case_folded_substring_matcher_test;
    import cfsm_pkg::*;

    // watchdog limit on cycles without any handshake
    localparam int STALL_LIMIT = 3000;
    // long receiver hold-off to fill the pipeline
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 100;
    // cycles to let the pipeline drain at the end
    localparam int DRAIN_CYCLES = 20;
    // cap on printed mismatches
    localparam int REPORT_CAP = 50;

    typedef struct {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic              first;
        int                phase;
    } char_item_t;

    // per phase idle percentages, sender then receiver
    int tx_idle [3] = '{35, 46, 0};
    int rx_idle [3] = '{46, 35, 0};

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // char_value[7:0], first_flag[8]
    logic                   s_tuser  = 1'b0; // opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // match_found[0], match_start[16:1],
                                             // match_count[32:17], pattern_overflow[33]

    case_folded_substring_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // characters waiting to be sent and the scan results they should give
    char_item_t char_queue [$];
    result_t    scan_results [$];

    // matcher state as predicted
    logic [CHAR_W-1:0] pat_bytes [PAT_MAX];
    logic [LEN_W-1:0]  pat_len = '0;
    logic [CHAR_W-1:0] window [PAT_MAX];
    logic [POS_W-1:0]  text_pos = '0;
    logic [POS_W-1:0]  hit_total = '0;
    logic              pat_dropped = 1'b0;

    char_item_t bus_item;
    int  fill_phase   = 0;
    int  tx_phase     = 0;
    int  items_queued = 0;
    int  items_in     = 0;
    int  results_out  = 0;
    int  fail_count   = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    int  stall_cycles = 0;

    initial begin
        foreach (window[i]) window[i] = '0;
        foreach (pat_bytes[i]) pat_bytes[i] = '0;
    end

    // predict the result of one accepted character
    task automatic scan_char(input logic op, input logic [CHAR_W-1:0] raw, input logic first);
        logic [CHAR_W-1:0] c;
        result_t r;
        logic same;
        int idx;
        c = raw;
        if (raw >= CHAR_LOWER_A && raw <= CHAR_LOWER_Z) begin
            c = raw - CASE_OFFSET;
        end
        r = '0;
        if (op == OP_PATTERN) begin
            if (first) begin
                pat_len = '0;
                pat_dropped = 1'b0;
            end
            if (int'(pat_len) < PAT_MAX) begin
                pat_bytes[pat_len[LEN_W-2:0]] = c;
                pat_len = pat_len + 1'b1;
            end else begin
                pat_dropped = 1'b1;
            end
        end else begin
            if (first) begin
                text_pos = '0;
                hit_total = '0;
                foreach (window[i]) window[i] = '0;
            end
            idx = int'(text_pos);
            // newest character in entry 0
            for (int i = PAT_MAX - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = c;
            if (pat_len != 0 && idx + 1 >= int'(pat_len)) begin
                same = 1'b1;
                for (int j = 0; j < int'(pat_len); j++) begin
                    if (window[int'(pat_len) - 1 - j] != pat_bytes[j]) same = 1'b0;
                end
                if (same) begin
                    r.found = 1'b1;
                    r.start = POS_W'(idx + 1 - int'(pat_len));
                    if (hit_total != POS_LIMIT) hit_total = hit_total + 1'b1;
                end
            end
            if (text_pos != POS_LIMIT) text_pos = text_pos + 1'b1;
        end
        r.count = hit_total;
        r.overflow = pat_dropped;
        scan_results.push_back(r);
    endtask

    // compare one received result with the oldest prediction
    task automatic check_result(input result_t got);
        result_t want;
        if (scan_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP) $error("result item with nothing predicted");
        end else begin
            want = scan_results.pop_front();
            if (got.found !== want.found) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("match_found: expected %0d, got %0d", want.found, got.found);
            end
            if (got.start !== want.start) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("match_start: expected %0d, got %0d", want.start, got.start);
            end
            if (got.count !== want.count) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("match_count: expected %0d, got %0d", want.count, got.count);
            end
            if (got.overflow !== want.overflow) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("pattern_overflow: expected %0d, got %0d",
                           want.overflow, got.overflow);
            end
        end
    endtask

    // stimulus helpers
    task automatic add_char(input logic op, input logic [CHAR_W-1:0] ch, input logic first);
        char_item_t it;
        it.op = op;
        it.ch = ch;
        it.first = first;
        it.phase = fill_phase;
        char_queue.push_back(it);
        items_queued++;
    endtask

    task automatic add_string(input logic op, input string s, input logic first);
        for (int i = 0; i < s.len(); i++) add_char(op, s[i], first && i == 0);
    endtask

    // flip the case of a letter at random, leave anything else alone
    function automatic logic [CHAR_W-1:0] rand_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] low;
        low = c | 8'h20;
        if (low >= CHAR_LOWER_A && low <= CHAR_LOWER_Z) begin
            return $urandom_range(0, 1) ? low : (low & 8'hdf);
        end
        return c;
    endfunction

    // small alphabet so that matches are frequent, with the odd raw byte
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 7))
            0, 1:    return 8'h61;
            2, 3:    return 8'h42;
            4:       return 8'h7a;
            5:       return 8'h00;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly pattern-then-text sessions with planted copies, some noise
    task automatic random_block(input int budget);
        int start_count;
        int plen;
        int tlen;
        int n;
        logic [CHAR_W-1:0] pat [$];
        start_count = items_queued;
        while (items_queued - start_count < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                pat.delete();
                plen = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
                for (int i = 0; i < plen; i++) begin
                    pat.push_back(pick_char());
                    add_char(OP_PATTERN, rand_case(pat[i]), i == 0);
                end
                tlen = $urandom_range(4, 30);
                n = 0;
                while (n < tlen) begin
                    if ($urandom_range(0, 2) == 0) begin
                        foreach (pat[i]) begin
                            add_char(OP_TEXT, rand_case(pat[i]),
                                     n == 0 && i == 0 && $urandom_range(0, 3) != 0);
                        end
                        n += plen;
                    end else begin
                        add_char(OP_TEXT, rand_case(pick_char()),
                                 n == 0 && $urandom_range(0, 3) != 0);
                        n++;
                    end
                end
            end else begin
                // noise: any opcode, any byte, restarts at random
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    add_char(logic'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                             $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    // clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // sender side: offer the next queued character, idle at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_char(bus_item.op, bus_item.ch, bus_item.first);
                items_in++;
                tx_phase <= bus_item.phase;
            end
            if (!s_tvalid || s_tready) begin
                if (char_queue.size() > 0 &&
                    $urandom_range(0, 99) >= tx_idle[char_queue[0].phase]) begin
                    bus_item = char_queue.pop_front();
                    s_tdata  <= {{(IN_TDATA_W - CHAR_W - 1){1'b0}}, bus_item.first, bus_item.ch};
                    s_tuser  <= bus_item.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver side: check results, stall at random, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(result_t'(m_tdata[RESULT_W-1:0]));
                results_out++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (results_out >= HOLD_AFTER && !hold_done) begin
                // the sender keeps offering so the block backs up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle[tx_phase]);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        // phase 0: sender idles 35 percent, receiver 46
        fill_phase = 0;

        // empty pattern after reset never matches
        add_string(OP_TEXT, "ab", 1'b1);

        // zero bytes as pattern, with too few text bytes at first
        add_char(OP_PATTERN, 8'h00, 1'b1);
        add_char(OP_PATTERN, 8'h00, 1'b0);
        add_char(OP_TEXT, 8'h00, 1'b1);
        add_char(OP_TEXT, 8'h00, 1'b0);
        add_char(OP_TEXT, 8'h00, 1'b0);

        // case folding and overlapping hits
        add_string(OP_PATTERN, "aB", 1'b1);
        add_string(OP_TEXT, "xAbab", 1'b1);

        // new pattern mid-text, compared against the window already held
        add_string(OP_PATTERN, "aa", 1'b1);
        add_string(OP_TEXT, "aA", 1'b0);

        // folding limits: only a to z move, the neighbours stay
        add_char(OP_PATTERN, 8'hff, 1'b1);
        add_char(OP_PATTERN, 8'h60, 1'b0);
        add_char(OP_PATTERN, 8'h7b, 1'b0);
        add_char(OP_TEXT, 8'hff, 1'b1);
        add_char(OP_TEXT, 8'h40, 1'b0);
        add_char(OP_TEXT, 8'h5b, 1'b0);
        add_char(OP_TEXT, 8'hff, 1'b0);
        add_char(OP_TEXT, 8'h60, 1'b0);
        add_char(OP_TEXT, 8'h7b, 1'b0);

        random_block(30);

        // phase 1: the other way round
        fill_phase = 1;

        // pattern that fills the store exactly, then found in the text
        begin
            logic [CHAR_W-1:0] full [PAT_MAX];
            foreach (full[i]) begin
                full[i] = pick_char();
                add_char(OP_PATTERN, rand_case(full[i]), i == 0);
            end
            add_string(OP_TEXT, "zz", 1'b1);
            foreach (full[i]) add_char(OP_TEXT, rand_case(full[i]), 1'b0);
            foreach (full[i]) add_char(OP_TEXT, rand_case(full[i]), 1'b0);
            // a few more bytes than the store holds, the rest is dropped
            for (int i = 0; i < PAT_MAX + 6; i++) begin
                add_char(OP_PATTERN, (i < PAT_MAX) ? full[i] : pick_char(), i == 0);
            end
            foreach (full[i]) add_char(OP_TEXT, full[i], i == 0);
            // a restart clears the overflow flag
            add_string(OP_PATTERN, "b", 1'b1);
            add_string(OP_TEXT, "Bb", 1'b0);
        end

        random_block(20);

        // phase 2: no idling, a run of one repeated character
        fill_phase = 2;
        add_string(OP_PATTERN, "q", 1'b1);
        for (int i = 0; i < 8; i++) begin
            add_char(OP_TEXT, rand_case(8'h71), i == 0);
        end
        add_string(OP_PATTERN, "qqq", 1'b1);
        add_string(OP_TEXT, "QqQq", 1'b0);
        random_block(10);

        // hold reset, then release it
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every item to go in and every result to come out
        while (char_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (scan_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d items and checked %0d results over three idling phases,",
                 items_in, results_out);
        $display("incl. pattern overflow, mid-text pattern change and a long output stall");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
